// ===== sv/atd_pkg.sv =====
package atd_pkg;

  localparam int unsigned SampleW = 12;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned CmpW    = 14;  // signed bounds span -255 .. 4350
  localparam int unsigned NarrowShift = 4;
  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [1:0] {
    BAND_OFF   = 2'd0,
    BAND_UPPER = 2'd1,
    BAND_LOWER = 2'd2
  } band_e;

  typedef enum logic [1:0] {
    KIND_UPPER = 2'd0,
    KIND_LOWER = 2'd1,
    KIND_SETUP = 2'd2
  } kind_e;

  localparam logic [1:0] REQ_NORMAL = 2'd0;
  localparam logic [1:0] REQ_SAVE   = 2'd2;

  localparam logic [CfgIdxW-1:0] REG_SENSOR_MODE     = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_CENTRE_OFFSET   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_TRIP_THRESHOLD  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_HYSTERESIS_BAND = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_INVERT_EVENTS   = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_SUPPRESS_OFF    = 3'd5;

  localparam logic [SampleW-1:0] OffsetReset = 12'd2048;
  localparam logic [ByteW-1:0]   ThreshReset = 8'd128;
  localparam logic [ByteW-1:0]   HystReset   = 8'd4;

  typedef struct packed {
    logic               sensor_mode;
    logic [SampleW-1:0] centre_offset;
    logic [ByteW-1:0]   trip_threshold;
    logic [ByteW-1:0]   hysteresis_band;
    logic               invert_events;
    logic               suppress_off;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic               event_on;
    logic [SampleW-1:0] reading;
    logic               save_offset;
    logic               last_result;
  } result_t;

endpackage

// ===== sv/analogue_threshold_event_detector.sv =====
// channel   direction  handshake               payload
// input     in         in_valid_i/in_ready_o   sample_i, setup_request_i
// result    out        out_valid_o/out_ready_i result_kind_o, event_on_o, reading_o,
//                                              save_offset_o, last_result_o
// config    in         cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// a sample is registered, evaluated combinationally and its results land in a
// two-entry result register; the first result is valid from that register
// one sample per cycle while each yields at most one result and the port is ready;
// two results hold the next sample until both drain, set by the single result port
// reset clears the band state and the armed flag and restores config defaults
// a stalled result port backs up into the input register and then in_ready_o
module analogue_threshold_event_detector (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [atd_pkg::SampleW-1:0]         sample_i,
  input  logic [1:0]                          setup_request_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [1:0]                          result_kind_o,
  output logic                                event_on_o,
  output logic [atd_pkg::SampleW-1:0]         reading_o,
  output logic                                save_offset_o,
  output logic                                last_result_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [atd_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [atd_pkg::SampleW-1:0]         cfg_data_i
);

  atd_pkg::cfg_t cfg_q, cfg_d;
  atd_pkg::band_e band_q, band_next;
  logic armed_q;

  logic s1_valid_q;
  logic [atd_pkg::SampleW-1:0] s1_sample_q;
  logic [1:0] s1_req_q;
  logic s1_fire, buf_free;

  atd_pkg::result_t res0, res1, head;
  logic [1:0] res_cnt;

  assign cfg_ready_o = 1'b1;
  assign s1_fire     = s1_valid_q && buf_free;
  assign in_ready_o  = !s1_valid_q || s1_fire;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        atd_pkg::REG_SENSOR_MODE:     cfg_d.sensor_mode     = cfg_data_i[0];
        atd_pkg::REG_CENTRE_OFFSET:   cfg_d.centre_offset   = cfg_data_i;
        atd_pkg::REG_TRIP_THRESHOLD:  cfg_d.trip_threshold  = cfg_data_i[atd_pkg::ByteW-1:0];
        atd_pkg::REG_HYSTERESIS_BAND: cfg_d.hysteresis_band = cfg_data_i[atd_pkg::ByteW-1:0];
        atd_pkg::REG_INVERT_EVENTS:   cfg_d.invert_events   = cfg_data_i[0];
        atd_pkg::REG_SUPPRESS_OFF:    cfg_d.suppress_off    = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sensor_mode     <= 1'b0;
      cfg_q.centre_offset   <= atd_pkg::OffsetReset;
      cfg_q.trip_threshold  <= atd_pkg::ThreshReset;
      cfg_q.hysteresis_band <= atd_pkg::HystReset;
      cfg_q.invert_events   <= 1'b0;
      cfg_q.suppress_off    <= 1'b0;
      band_q                <= atd_pkg::BAND_OFF;
      armed_q               <= 1'b0;
      s1_valid_q            <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (s1_fire) begin
        band_q  <= band_next;
        armed_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_sample_q <= sample_i;
      s1_req_q    <= setup_request_i;
    end
  end

  atd_eval u_eval (
    .cfg_i           (cfg_q),
    .band_i          (band_q),
    .armed_i         (armed_q),
    .sample_i        (s1_sample_q),
    .setup_request_i (s1_req_q),
    .band_o          (band_next),
    .res0_o          (res0),
    .res1_o          (res1),
    .res_cnt_o       (res_cnt)
  );

  atd_result_buf u_result_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (s1_fire),
    .load_cnt_i  (res_cnt),
    .res0_i      (res0),
    .res1_i      (res1),
    .free_o      (buf_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .head_o      (head)
  );

  assign result_kind_o = head.kind;
  assign event_on_o    = head.event_on;
  assign reading_o     = head.reading;
  assign save_offset_o = head.save_offset;
  assign last_result_o = head.last_result;

endmodule

// ===== sv/atd_eval.sv =====
module atd_eval (
  input  atd_pkg::cfg_t                  cfg_i,
  input  atd_pkg::band_e                 band_i,
  input  logic                           armed_i,
  input  logic [atd_pkg::SampleW-1:0]    sample_i,
  input  logic [1:0]                     setup_request_i,
  output atd_pkg::band_e                 band_o,
  output atd_pkg::result_t               res0_o,
  output atd_pkg::result_t               res1_o,
  output logic [1:0]                     res_cnt_o
);

  logic signed [atd_pkg::CmpW-1:0] adc, hthr, hhys, lthr, lhys;
  logic signed [atd_pkg::CmpW-1:0] off_s, thr_s, hys_s;
  atd_pkg::band_e band_mid;
  logic up_ev, up_on, lo_ev, lo_on;
  logic on_pol, off_pol;
  atd_pkg::result_t up_res, lo_res, setup_res;

  assign off_s = $signed({2'b00, cfg_i.centre_offset});
  assign thr_s = $signed({6'b000000, cfg_i.trip_threshold});
  assign hys_s = $signed({6'b000000, cfg_i.hysteresis_band});

  assign on_pol  = ~cfg_i.invert_events;
  assign off_pol = cfg_i.invert_events;

  always_comb begin
    if (cfg_i.sensor_mode) begin
      adc  = $signed({2'b00, sample_i});
      hthr = off_s + thr_s;
      hhys = hthr - hys_s;
      lthr = off_s - thr_s;
      lhys = lthr + hys_s;
    end else begin
      adc  = $signed({6'b000000, sample_i[atd_pkg::SampleW-1:atd_pkg::NarrowShift]});
      hthr = '0;
      hhys = '0;
      lthr = thr_s;
      lhys = thr_s + hys_s;
    end
  end

  // upper side, magnet mode only
  always_comb begin
    band_mid = band_i;
    up_ev    = 1'b0;
    up_on    = 1'b0;
    if (cfg_i.sensor_mode) begin
      if (band_i != atd_pkg::BAND_UPPER && adc >= hthr) begin
        band_mid = atd_pkg::BAND_UPPER;
        up_ev    = armed_i;
        up_on    = 1'b1;
      end else if (band_i == atd_pkg::BAND_UPPER && adc <= hhys) begin
        band_mid = atd_pkg::BAND_OFF;
        up_ev    = armed_i & ~cfg_i.suppress_off;
      end
    end
  end

  // lower side sees the state left by the upper test
  always_comb begin
    band_o = band_mid;
    lo_ev  = 1'b0;
    lo_on  = 1'b0;
    if (band_mid != atd_pkg::BAND_LOWER && adc <= lthr) begin
      band_o = atd_pkg::BAND_LOWER;
      lo_ev  = armed_i;
      lo_on  = 1'b1;
    end else if (band_mid == atd_pkg::BAND_LOWER && adc >= lhys) begin
      band_o = atd_pkg::BAND_OFF;
      lo_ev  = armed_i & ~cfg_i.suppress_off;
    end
    if (setup_request_i != atd_pkg::REQ_NORMAL) begin
      band_o = band_i;
    end
  end

  always_comb begin
    up_res             = '0;
    up_res.kind        = atd_pkg::KIND_UPPER;
    up_res.event_on    = up_on ? on_pol : off_pol;
    up_res.last_result = ~lo_ev;

    lo_res             = '0;
    lo_res.kind        = atd_pkg::KIND_LOWER;
    lo_res.event_on    = lo_on ? on_pol : off_pol;
    lo_res.last_result = 1'b1;

    setup_res             = '0;
    setup_res.kind        = atd_pkg::KIND_SETUP;
    setup_res.reading     = sample_i;
    setup_res.save_offset = (setup_request_i == atd_pkg::REQ_SAVE);
    setup_res.last_result = 1'b1;
  end

  always_comb begin
    if (setup_request_i != atd_pkg::REQ_NORMAL) begin
      res0_o    = setup_res;
      res1_o    = setup_res;
      res_cnt_o = 2'd1;
    end else if (up_ev) begin
      res0_o    = up_res;
      res1_o    = lo_res;
      res_cnt_o = lo_ev ? 2'd2 : 2'd1;
    end else begin
      res0_o    = lo_res;
      res1_o    = lo_res;
      res_cnt_o = {1'b0, lo_ev};
    end
  end

endmodule

// ===== sv/atd_result_buf.sv =====
module atd_result_buf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  logic [1:0]       load_cnt_i,
  input  atd_pkg::result_t res0_i,
  input  atd_pkg::result_t res1_i,
  output logic             free_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output atd_pkg::result_t head_o
);

  logic [1:0] cnt_q, cnt_d;
  atd_pkg::result_t r0_q, r0_d, r1_q, r1_d;
  logic pop;

  assign pop         = (cnt_q != 2'd0) && out_ready_i;
  assign free_o      = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop);
  assign out_valid_o = (cnt_q != 2'd0);
  assign head_o      = r0_q;

  always_comb begin
    cnt_d = cnt_q;
    r0_d  = r0_q;
    r1_d  = r1_q;
    if (load_i) begin
      cnt_d = load_cnt_i;
      r0_d  = res0_i;
      r1_d  = res1_i;
    end else if (pop) begin
      cnt_d = cnt_q - 2'd1;
      r0_d  = r1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r0_q <= r0_d;
    r1_q <= r1_d;
  end

endmodule

// ===== sv/atd_checker.sv =====
module atd_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [1:0]                  result_kind_o,
  input logic                        event_on_o,
  input logic [atd_pkg::SampleW-1:0] reading_o,
  input logic                        save_offset_o,
  input logic                        last_result_o
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_kind_o)
      && $stable(event_on_o) && $stable(reading_o) && $stable(last_result_o))
    else $error("result beat changed under stall");

  // a setup report is always alone and carries no polarity
  a_setup_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o == atd_pkg::KIND_SETUP |-> last_result_o && !event_on_o)
    else $error("setup report not a lone beat");

  // events never carry a reading or a save flag
  a_event_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o != atd_pkg::KIND_SETUP |-> reading_o == '0 && !save_offset_o)
    else $error("event beat carries reading");

  // a non-last beat is an upper event followed at once by the lower event
  a_pair_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_result_o |=>
      out_valid_o && result_kind_o == atd_pkg::KIND_LOWER && last_result_o)
    else $error("second result of a sample missing");

endmodule

bind analogue_threshold_event_detector atd_checker u_atd_checker (.*);
